FILE: src/eipf_pkg.sv
// shared types and constants for the ethernet ipv4 tcp/udp header filter
package eipf_pkg;

    // verdict codes
    typedef enum logic [2:0] {
        VERDICT_DROP    = 3'd0,
        VERDICT_ACCEPT  = 3'd1,
        VERDICT_UNKNOWN = 3'd2,
        VERDICT_ENIP    = 3'd3,
        VERDICT_TRUNC   = 3'd4
    } t_verdict;

    // transport seen
    typedef enum logic [1:0] {
        L4_NONE = 2'd0,
        L4_TCP  = 2'd1,
        L4_UDP  = 2'd2
    } t_l4_kind;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SRC_IP   = 3'd0,
        REG_DST_IP   = 3'd1,
        REG_ANY_IP   = 3'd2,
        REG_SRC_PORT = 3'd3,
        REG_DST_PORT = 3'd4,
        REG_ANY_PORT = 3'd5
    } t_reg_idx;

    // filter settings, zero means any
    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] any_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] any_port;
    } t_filter_cfg;

    // one verdict transaction
    typedef struct packed {
        t_verdict    verdict;
        t_l4_kind    l4_kind;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_result;

    // ethertype values
    localparam logic [15:0] ETH_LEN_LIMIT = 16'd1500;
    localparam logic [15:0] ET_LLDP       = 16'h88cc;
    localparam logic [15:0] ET_VLAN       = 16'h8100;
    localparam logic [15:0] ET_ARP        = 16'h0806;
    localparam logic [15:0] ET_IPV6       = 16'h86dd;
    localparam logic [15:0] ET_IPV4       = 16'h0800;

    // ip protocol numbers
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // well known ports and ethernet/ip commands
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_ENIP  = 16'd44818;
    localparam logic [15:0] ENIP_REG   = 16'h0065;
    localparam logic [15:0] ENIP_UNREG = 16'h0066;
    localparam logic [15:0] ENIP_RR    = 16'h006f;
    localparam logic [15:0] ENIP_UNIT  = 16'h0070;

    // frame byte offsets
    localparam logic [15:0] OFF_ETYPE_HI = 16'd12;
    localparam logic [15:0] OFF_ETYPE_LO = 16'd13;
    localparam logic [15:0] OFF_LEN_HI   = 16'd16;
    localparam logic [15:0] OFF_LEN_LO   = 16'd17;
    localparam logic [15:0] OFF_PROTO    = 16'd23;
    localparam logic [15:0] OFF_SRC_IP0  = 16'd26;
    localparam logic [15:0] OFF_SRC_IP3  = 16'd29;
    localparam logic [15:0] OFF_DST_IP0  = 16'd30;
    localparam logic [15:0] OFF_DST_IP3  = 16'd33;
    localparam logic [15:0] OFF_SPORT_HI = 16'd34;
    localparam logic [15:0] OFF_SPORT_LO = 16'd35;
    localparam logic [15:0] OFF_DPORT_HI = 16'd36;
    localparam logic [15:0] OFF_DPORT_LO = 16'd37;
    localparam logic [15:0] OFF_PORTS_END = 16'd38;
    localparam logic [15:0] OFF_TCP_DOFF = 16'd46;
    localparam logic [15:0] TCP_BASE     = 16'd34;
    localparam logic [15:0] IP_HDR_BYTES = 16'd20;
    localparam logic [5:0]  TCP_MIN_HDR  = 6'd20;

endpackage

FILE: src/eth_ipv4_l4_packet_filter.sv
// top level of the ethernet ipv4 tcp/udp header filter
//
// Frame bytes enter on the s_axis stream one per transaction, tlast on the
// final captured byte. For every frame exactly one verdict transaction leaves
// on the m_axis stream, carrying the verdict, the transport kind and the
// source and destination ports. Filter addresses and ports are set through
// the apb port (zero means any); they are to be changed only while no frame
// is open, which the user must ensure, as the block does not enforce it.
// A byte is held in an input register and is parsed as it leaves it; the
// verdict is loaded into the output register as the tlast byte is parsed.
// Throughput: one byte per clock while no verdict is stuck in the output
// register, set by the combinational parse step between the input register
// and the state/output registers. When the receiver stalls with a verdict
// waiting, at most one more byte is taken into the input register and
// s_axis tready drops until the verdict is taken. Synchronous active-low
// reset clears the frame state, the filters and both stream valid flags.
module eth_ipv4_l4_packet_filter
    import eipf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // frame byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] frame_byte
    input  logic        i_s_axis_tlast,   // last_byte
    // verdict stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [2:0] verdict, [4:3] l4_kind,
                                          // [20:5] src_port, [36:21] dst_port
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_filter_cfg r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     parse_result;
    logic        advance;
    logic        step;
    t_reg_idx    reg_idx;

    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_SRC_IP:   r_cfg.src_ip   <= pwdata;
                REG_DST_IP:   r_cfg.dst_ip   <= pwdata;
                REG_ANY_IP:   r_cfg.any_ip   <= pwdata;
                REG_SRC_PORT: r_cfg.src_port <= pwdata[15:0];
                REG_DST_PORT: r_cfg.dst_port <= pwdata[15:0];
                REG_ANY_PORT: r_cfg.any_port <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // configuration reads
    always_comb begin
        unique case (reg_idx)
            REG_SRC_IP:   prdata = r_cfg.src_ip;
            REG_DST_IP:   prdata = r_cfg.dst_ip;
            REG_ANY_IP:   prdata = r_cfg.any_ip;
            REG_SRC_PORT: prdata = {16'd0, r_cfg.src_port};
            REG_DST_PORT: prdata = {16'd0, r_cfg.dst_port};
            REG_ANY_PORT: prdata = {16'd0, r_cfg.any_port};
            default:      prdata = 32'd0;
        endcase
    end

    // pipeline moves unless a verdict is stuck in the output register
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    eipf_frame_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (r_cfg),
        .o_result (parse_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= parse_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.dst_port, r_out.src_port,
                              r_out.l4_kind, r_out.verdict};

endmodule

FILE: src/eipf_frame_parser.sv
// per-frame header parse state and verdict logic, one byte per step
module eipf_frame_parser
    import eipf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  t_filter_cfg i_cfg,
    output t_result     o_result
);

    logic [15:0] r_offset,    n_offset;
    logic [15:0] r_ether_type, n_ether_type;
    logic [7:0]  r_ip_proto,  n_ip_proto;
    logic [15:0] r_total_len, n_total_len;
    logic [31:0] r_src_addr,  n_src_addr;
    logic [31:0] r_dst_addr,  n_dst_addr;
    logic [15:0] r_src_port,  n_src_port;
    logic [15:0] r_dst_port,  n_dst_port;
    logic [5:0]  r_tcp_hdr,   n_tcp_hdr;
    logic [7:0]  r_cmd_lo,    n_cmd_lo;
    t_verdict    r_held,      n_held;
    logic        r_decided,   n_decided;
    t_l4_kind    r_l4,        n_l4;

    logic [15:0] et_full;
    logic [15:0] cmd_full;
    logic [15:0] pstart;
    logic [5:0]  hdr_new;
    logic        port_https;
    logic        port_enip;
    logic        ports_ok;

    // helper values for the current byte
    always_comb begin
        et_full    = {r_ether_type[15:8], i_byte};
        cmd_full   = {i_byte, r_cmd_lo};
        pstart     = TCP_BASE + {10'd0, r_tcp_hdr};
        hdr_new    = {i_byte[7:4], 2'b00};
        port_https = (r_src_port == PORT_HTTPS) || (r_dst_port == PORT_HTTPS);
        port_enip  = (r_src_port == PORT_ENIP) || (r_dst_port == PORT_ENIP);
    end

    // next parse state
    always_comb begin
        n_offset     = (r_offset != 16'hffff) ? r_offset + 16'd1 : r_offset;
        n_ether_type = r_ether_type;
        n_ip_proto   = r_ip_proto;
        n_total_len  = r_total_len;
        n_src_addr   = r_src_addr;
        n_dst_addr   = r_dst_addr;
        n_src_port   = r_src_port;
        n_dst_port   = r_dst_port;
        n_tcp_hdr    = r_tcp_hdr;
        n_cmd_lo     = r_cmd_lo;
        n_held       = r_held;
        n_decided    = r_decided;
        n_l4         = r_l4;

        if (!r_decided) begin
            if (r_offset == OFF_ETYPE_HI) begin
                n_ether_type = {i_byte, 8'd0};
            end else if (r_offset == OFF_ETYPE_LO) begin
                // ethertype classification
                n_ether_type = et_full;
                if (et_full < ETH_LEN_LIMIT) begin
                    n_held = VERDICT_ACCEPT;  n_decided = 1'b1;
                end else if (et_full == ET_LLDP || et_full == ET_VLAN ||
                             et_full == ET_ARP || et_full == ET_IPV6) begin
                    n_held = VERDICT_DROP;    n_decided = 1'b1;
                end else if (et_full != ET_IPV4) begin
                    n_held = VERDICT_UNKNOWN; n_decided = 1'b1;
                end
            end else if (r_offset == OFF_LEN_HI) begin
                n_total_len = {i_byte, 8'd0};
            end else if (r_offset == OFF_LEN_LO) begin
                n_total_len = {r_total_len[15:8], i_byte};
            end else if (r_offset == OFF_PROTO) begin
                n_ip_proto = i_byte;
            end else if (r_offset >= OFF_SRC_IP0 && r_offset <= OFF_SRC_IP3) begin
                n_src_addr = {r_src_addr[23:0], i_byte};
            end else if (r_offset >= OFF_DST_IP0 && r_offset <= OFF_DST_IP3) begin
                n_dst_addr = {r_dst_addr[23:0], i_byte};
                // address filters then protocol
                if (r_offset == OFF_DST_IP3) begin
                    if ((i_cfg.src_ip != 32'd0 && r_src_addr != i_cfg.src_ip) ||
                        (i_cfg.dst_ip != 32'd0 && n_dst_addr != i_cfg.dst_ip) ||
                        (i_cfg.any_ip != 32'd0 && r_src_addr != i_cfg.any_ip &&
                         n_dst_addr != i_cfg.any_ip)) begin
                        n_held = VERDICT_DROP;    n_decided = 1'b1;
                    end else if (r_ip_proto == PROTO_TCP) begin
                        n_l4 = L4_TCP;
                    end else if (r_ip_proto == PROTO_UDP) begin
                        n_l4 = L4_UDP;
                    end else if (r_ip_proto == PROTO_ICMP || r_ip_proto == PROTO_IGMP) begin
                        n_held = VERDICT_DROP;    n_decided = 1'b1;
                    end else begin
                        n_held = VERDICT_UNKNOWN; n_decided = 1'b1;
                    end
                end
            end else if (r_offset == OFF_SPORT_HI || r_offset == OFF_SPORT_LO) begin
                n_src_port = {r_src_port[7:0], i_byte};
            end else if (r_offset == OFF_DPORT_HI || r_offset == OFF_DPORT_LO) begin
                n_dst_port = {r_dst_port[7:0], i_byte};
                // port filters
                if (r_offset == OFF_DPORT_LO) begin
                    if ((i_cfg.src_port != 16'd0 && r_src_port != i_cfg.src_port) ||
                        (i_cfg.dst_port != 16'd0 && n_dst_port != i_cfg.dst_port) ||
                        (i_cfg.any_port != 16'd0 && r_src_port != i_cfg.any_port &&
                         n_dst_port != i_cfg.any_port)) begin
                        n_held = VERDICT_DROP;   n_decided = 1'b1;
                    end else if (r_l4 == L4_UDP) begin
                        n_held = VERDICT_ACCEPT; n_decided = 1'b1;
                    end
                end
            end else if (r_offset == OFF_TCP_DOFF) begin
                // tcp data offset and payload length
                n_tcp_hdr = hdr_new;
                if (hdr_new < TCP_MIN_HDR) begin
                    n_held = VERDICT_UNKNOWN; n_decided = 1'b1;
                end else if (r_total_len == IP_HDR_BYTES + {10'd0, hdr_new}) begin
                    n_held = VERDICT_ACCEPT;  n_decided = 1'b1;
                end else if (r_total_len != IP_HDR_BYTES + 16'd1 + {10'd0, hdr_new}) begin
                    if (port_https || !port_enip) begin
                        n_held = VERDICT_ACCEPT; n_decided = 1'b1;
                    end
                end
            end else if (r_offset > OFF_TCP_DOFF && r_offset == pstart) begin
                // first payload byte
                n_cmd_lo = i_byte;
                if (r_total_len == IP_HDR_BYTES + 16'd1 + {10'd0, r_tcp_hdr}) begin
                    if (i_byte == 8'd0 || port_https || !port_enip) begin
                        n_held = VERDICT_ACCEPT; n_decided = 1'b1;
                    end
                end
            end else if (r_offset > OFF_TCP_DOFF && r_offset == pstart + 16'd1) begin
                // ethernet/ip command word
                n_decided = 1'b1;
                if (cmd_full == ENIP_REG || cmd_full == ENIP_UNREG ||
                    cmd_full == ENIP_RR || cmd_full == ENIP_UNIT) begin
                    n_held = VERDICT_ENIP;
                end else begin
                    n_held = VERDICT_UNKNOWN;
                end
            end
        end
    end

    // result for a frame ending on this byte
    always_comb begin
        ports_ok          = (n_l4 != L4_NONE) && (n_offset >= OFF_PORTS_END);
        o_result.verdict  = n_held;
        o_result.l4_kind  = n_l4;
        o_result.src_port = ports_ok ? n_src_port : 16'd0;
        o_result.dst_port = ports_ok ? n_dst_port : 16'd0;
    end

    // state registers, cleared after every frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_offset     <= 16'd0;
            r_ether_type <= 16'd0;
            r_ip_proto   <= 8'd0;
            r_total_len  <= 16'd0;
            r_src_addr   <= 32'd0;
            r_dst_addr   <= 32'd0;
            r_src_port   <= 16'd0;
            r_dst_port   <= 16'd0;
            r_tcp_hdr    <= 6'd0;
            r_cmd_lo     <= 8'd0;
            r_held       <= VERDICT_TRUNC;
            r_decided    <= 1'b0;
            r_l4         <= L4_NONE;
        end else if (i_step) begin
            r_offset     <= n_offset;
            r_ether_type <= n_ether_type;
            r_ip_proto   <= n_ip_proto;
            r_total_len  <= n_total_len;
            r_src_addr   <= n_src_addr;
            r_dst_addr   <= n_dst_addr;
            r_src_port   <= n_src_port;
            r_dst_port   <= n_dst_port;
            r_tcp_hdr    <= n_tcp_hdr;
            r_cmd_lo     <= n_cmd_lo;
            r_held       <= n_held;
            r_decided    <= n_decided;
            r_l4         <= n_l4;
        end
    end

endmodule

FILE: verif/eth_ipv4_l4_packet_filter_tb.sv
// testbench for the ethernet ipv4 tcp/udp header filter: frame stimulus and verdict scoreboard
`timescale 1ns / 100ps

import eipf_pkg::*;

// verdict predictor and store of expected verdicts
class verdict_scoreboard;
    t_filter_cfg cfg;
    t_result     verdicts_due[$];
    int          errors;

    // frame parse state
    logic [15:0] offset;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] total_len;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [5:0]  tcp_hdr;
    logic [15:0] command;
    t_verdict    held;
    bit          decided;
    t_l4_kind    l4;

    function new();
        cfg = '0;
        errors = 0;
        clear();
    endfunction

    function void clear();
        offset = '0;
        etype = '0;
        proto = '0;
        total_len = '0;
        src_addr = '0;
        dst_addr = '0;
        sport = '0;
        dport = '0;
        tcp_hdr = '0;
        command = '0;
        held = VERDICT_TRUNC;
        decided = 1'b0;
        l4 = L4_NONE;
    endfunction

    function void settle(t_verdict v);
        held = v;
        decided = 1'b1;
    endfunction

    function bit either_port(logic [15:0] p);
        return (sport == p) || (dport == p);
    endfunction

    function int payload_len();
        return int'(total_len) - int'(IP_HDR_BYTES) - int'(tcp_hdr);
    endfunction

    // rules for a non-empty tcp payload, an enip port waits for the command
    function void tcp_port_rules();
        if (either_port(PORT_HTTPS)) begin
            settle(VERDICT_ACCEPT);
        end else if (!either_port(PORT_ENIP)) begin
            settle(VERDICT_ACCEPT);
        end
    endfunction

    // one frame byte at the current offset
    function void parse(logic [7:0] b);
        int pstart;
        pstart = int'(TCP_BASE) + int'(tcp_hdr);
        if (offset == OFF_ETYPE_HI) begin
            etype = {b, 8'h00};
        end else if (offset == OFF_ETYPE_LO) begin
            etype[7:0] = b;
            if (etype < ETH_LEN_LIMIT) begin
                settle(VERDICT_ACCEPT);
            end else if (etype == ET_LLDP || etype == ET_VLAN ||
                         etype == ET_ARP || etype == ET_IPV6) begin
                settle(VERDICT_DROP);
            end else if (etype != ET_IPV4) begin
                settle(VERDICT_UNKNOWN);
            end
        end else if (offset == OFF_LEN_HI) begin
            total_len = {b, 8'h00};
        end else if (offset == OFF_LEN_LO) begin
            total_len[7:0] = b;
        end else if (offset == OFF_PROTO) begin
            proto = b;
        end else if (offset >= OFF_SRC_IP0 && offset <= OFF_SRC_IP3) begin
            src_addr = {src_addr[23:0], b};
        end else if (offset >= OFF_DST_IP0 && offset <= OFF_DST_IP3) begin
            dst_addr = {dst_addr[23:0], b};
            // address filters, then the protocol
            if (offset == OFF_DST_IP3) begin
                if ((cfg.src_ip != 0 && src_addr != cfg.src_ip) ||
                    (cfg.dst_ip != 0 && dst_addr != cfg.dst_ip) ||
                    (cfg.any_ip != 0 && src_addr != cfg.any_ip &&
                     dst_addr != cfg.any_ip)) begin
                    settle(VERDICT_DROP);
                end else if (proto == PROTO_TCP) begin
                    l4 = L4_TCP;
                end else if (proto == PROTO_UDP) begin
                    l4 = L4_UDP;
                end else if (proto == PROTO_ICMP || proto == PROTO_IGMP) begin
                    settle(VERDICT_DROP);
                end else begin
                    settle(VERDICT_UNKNOWN);
                end
            end
        end else if (offset == OFF_SPORT_HI || offset == OFF_SPORT_LO) begin
            sport = {sport[7:0], b};
        end else if (offset == OFF_DPORT_HI || offset == OFF_DPORT_LO) begin
            dport = {dport[7:0], b};
            // port filters
            if (offset == OFF_DPORT_LO) begin
                if ((cfg.src_port != 0 && sport != cfg.src_port) ||
                    (cfg.dst_port != 0 && dport != cfg.dst_port) ||
                    (cfg.any_port != 0 && !either_port(cfg.any_port))) begin
                    settle(VERDICT_DROP);
                end else if (l4 == L4_UDP) begin
                    settle(VERDICT_ACCEPT);
                end
            end
        end else if (offset == OFF_TCP_DOFF) begin
            tcp_hdr = {b[7:4], 2'b00};
            if (tcp_hdr < TCP_MIN_HDR) begin
                settle(VERDICT_UNKNOWN);
            end else if (payload_len() == 0) begin
                settle(VERDICT_ACCEPT);
            end else if (payload_len() != 1) begin
                tcp_port_rules();
            end
        end else if (offset > OFF_TCP_DOFF && int'(offset) == pstart) begin
            command = {8'h00, b};
            if (payload_len() == 1) begin
                if (b == 8'h00) begin
                    settle(VERDICT_ACCEPT);
                end else begin
                    tcp_port_rules();
                end
            end
        end else if (offset > OFF_TCP_DOFF && int'(offset) == pstart + 1) begin
            command[15:8] = b;
            if (command == ENIP_REG || command == ENIP_UNREG ||
                command == ENIP_RR || command == ENIP_UNIT) begin
                settle(VERDICT_ENIP);
            end else begin
                settle(VERDICT_UNKNOWN);
            end
        end
    endfunction

    // accepted input transaction, a verdict is due on the last byte
    function void note_byte(logic [7:0] b, logic last);
        t_result v;
        bit      ports_ok;
        if (!decided) begin
            parse(b);
        end
        if (offset != 16'hffff) begin
            offset++;
        end
        if (last) begin
            ports_ok = (l4 != L4_NONE) && (offset >= OFF_PORTS_END);
            v.verdict  = held;
            v.l4_kind  = l4;
            v.src_port = ports_ok ? sport : 16'h0000;
            v.dst_port = ports_ok ? dport : 16'h0000;
            verdicts_due.push_back(v);
            clear();
        end
    endfunction

    // accepted output transaction against the oldest due verdict
    function void check_result(logic [39:0] data);
        t_result v;
        if (verdicts_due.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected verdict transaction: tdata %h", data);
            end
            return;
        end
        v = verdicts_due.pop_front();
        if (data[2:0] != v.verdict || data[4:3] != v.l4_kind ||
            data[20:5] != v.src_port || data[36:21] != v.dst_port ||
            data[39:37] != 3'b000) begin
            errors++;
            if (errors <= 10) begin
                $display("verdict mismatch: expected v=%0d l4=%0d sp=%0d dp=%0d pad=0",
                         v.verdict, v.l4_kind, v.src_port, v.dst_port);
                $display("                  actual   v=%0d l4=%0d sp=%0d dp=%0d pad=%0d",
                         data[2:0], data[4:3], data[20:5], data[36:21], data[39:37]);
            end
        end
    endfunction
endclass

module eth_ipv4_l4_packet_filter_tb;

    localparam int STALL_LIMIT = 2000;
    localparam int CFG_ZERO    = 0;
    localparam int CFG_ONES    = 1;
    localparam int CFG_RANDOM  = 2;

    // header fields of one generated frame
    typedef struct {
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [15:0] tot_len;
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        logic [7:0]  doff;
        logic [7:0]  pay0;
        logic [7:0]  pay1;
    } frame_desc_t;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'h0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [31:0] prdata;
    logic        pready;

    bit                no_idle = 1'b0;
    int                quiet_cycles = 0;
    verdict_scoreboard sb = new();

    eth_ipv4_l4_packet_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 15);
    end

    // verdict transaction monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no transaction on either stream
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("eth_ipv4_l4_packet_filter_tb NOT OK");
            $finish;
        end
    end

    // one frame byte transaction, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!no_idle && $urandom_range(0, 99) < 15) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!s_tready);
        sb.note_byte(b, last);
        @(negedge i_clk);
    endtask

    // frame byte at a given offset
    function automatic logic [7:0] frame_byte_at(frame_desc_t d, int i);
        int pstart;
        pstart = int'(TCP_BASE) + int'(d.doff[7:4]) * 4;
        if (i == OFF_ETYPE_HI) return d.etype[15:8];
        if (i == OFF_ETYPE_LO) return d.etype[7:0];
        if (i == OFF_LEN_HI) return d.tot_len[15:8];
        if (i == OFF_LEN_LO) return d.tot_len[7:0];
        if (i == OFF_PROTO) return d.proto;
        if (i >= OFF_SRC_IP0 && i <= OFF_SRC_IP3) return 8'(d.sa >> (8 * (OFF_SRC_IP3 - i)));
        if (i >= OFF_DST_IP0 && i <= OFF_DST_IP3) return 8'(d.da >> (8 * (OFF_DST_IP3 - i)));
        if (i == OFF_SPORT_HI) return d.sp[15:8];
        if (i == OFF_SPORT_LO) return d.sp[7:0];
        if (i == OFF_DPORT_HI) return d.dp[15:8];
        if (i == OFF_DPORT_LO) return d.dp[7:0];
        if (i == OFF_TCP_DOFF) return d.doff;
        if (i > OFF_TCP_DOFF && i == pstart) return d.pay0;
        if (i > OFF_TCP_DOFF && i == pstart + 1) return d.pay1;
        return 8'($urandom);
    endfunction

    task automatic send_frame(input frame_desc_t d, input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(frame_byte_at(d, i), i == len - 1);
        end
    endtask

    // wait for every due verdict, then for the pipeline to settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb register write, called and returning at a falling edge
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SRC_IP:   sb.cfg.src_ip   = value;
            REG_DST_IP:   sb.cfg.dst_ip   = value;
            REG_ANY_IP:   sb.cfg.any_ip   = value;
            REG_SRC_PORT: sb.cfg.src_port = value[15:0];
            REG_DST_PORT: sb.cfg.dst_port = value[15:0];
            REG_ANY_PORT: sb.cfg.any_port = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // register value for a filter setting, port writes may carry junk upper bits
    function automatic logic [31:0] cfg_word(int mode, bit is_port);
        case (mode)
            CFG_ZERO: return is_port ? {16'($urandom), 16'h0000} : 32'h0;
            CFG_ONES: return 32'hffff_ffff;
            default:  return ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom;
        endcase
    endfunction

    task automatic set_filters(input int mode);
        apb_write(REG_SRC_IP,   cfg_word(mode, 1'b0));
        apb_write(REG_DST_IP,   cfg_word(mode, 1'b0));
        apb_write(REG_ANY_IP,   cfg_word(mode, 1'b0));
        apb_write(REG_SRC_PORT, cfg_word(mode, 1'b1));
        apb_write(REG_DST_PORT, cfg_word(mode, 1'b1));
        apb_write(REG_ANY_PORT, cfg_word(mode, 1'b1));
    endtask

    function automatic frame_desc_t ipv4_desc(logic [7:0] proto, logic [15:0] sp,
                                              logic [15:0] dp, logic [7:0] doff, int plen);
        frame_desc_t d;
        d.etype   = ET_IPV4;
        d.proto   = proto;
        d.sa      = $urandom;
        d.da      = $urandom;
        d.sp      = sp;
        d.dp      = dp;
        d.doff    = doff;
        d.tot_len = 16'(20 + int'(doff[7:4]) * 4 + plen);
        d.pay0    = 8'($urandom);
        d.pay1    = 8'($urandom);
        return d;
    endfunction

    // addresses and ports lean toward the current filters so some frames pass
    function automatic logic [31:0] pick_addr(logic [31:0] own);
        case ($urandom_range(0, 7))
            0, 1, 2: return own;
            3:       return sb.cfg.any_ip;
            4:       return 32'h0;
            5:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port(logic [15:0] own);
        case ($urandom_range(0, 8))
            0, 1, 2: return own;
            3:       return sb.cfg.any_port;
            4:       return PORT_HTTPS;
            5:       return PORT_ENIP;
            6:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic frame_desc_t random_desc();
        frame_desc_t d;
        logic [15:0] cmd;
        int          plen;
        d = ipv4_desc(PROTO_TCP, pick_port(sb.cfg.src_port), pick_port(sb.cfg.dst_port),
                      8'h50, 0);
        d.sa = pick_addr(sb.cfg.src_ip);
        d.da = pick_addr(sb.cfg.dst_ip);
        // ethertype, mostly ipv4
        if ($urandom_range(0, 99) >= 75) begin
            case ($urandom_range(0, 7))
                0: d.etype = 16'($urandom_range(0, 1499));
                1: d.etype = ETH_LEN_LIMIT;
                2: d.etype = ET_LLDP;
                3: d.etype = ET_VLAN;
                4: d.etype = ET_ARP;
                5: d.etype = ET_IPV6;
                6: d.etype = 16'($urandom);
                default: d.etype = 16'hffff;
            endcase
        end
        // protocol, mostly tcp and udp
        case ($urandom_range(0, 19))
            0: d.proto = PROTO_ICMP;
            1: d.proto = PROTO_IGMP;
            2: d.proto = 8'($urandom);
            3, 4, 5, 6, 7, 8, 9: d.proto = PROTO_UDP;
            default: d.proto = PROTO_TCP;
        endcase
        // data offset, now and then below the minimum
        if ($urandom_range(0, 9) == 0) begin
            d.doff = {4'($urandom_range(0, 4)), 4'($urandom)};
        end else begin
            d.doff = {4'($urandom_range(5, 15)), 4'($urandom)};
        end
        case ($urandom_range(0, 9))
            0:       plen = 0;
            1, 2:    plen = 1;
            3:       plen = 2;
            default: plen = $urandom_range(3, 40);
        endcase
        d.tot_len = 16'(20 + int'(d.doff[7:4]) * 4 + plen);
        if ($urandom_range(0, 9) == 0) begin
            d.tot_len = 16'($urandom);
        end
        // payload start, often an enip command
        case ($urandom_range(0, 5))
            0: cmd = ENIP_REG;
            1: cmd = ENIP_UNREG;
            2: cmd = ENIP_RR;
            3: cmd = ENIP_UNIT;
            default: cmd = 16'($urandom);
        endcase
        d.pay0 = cmd[7:0];
        d.pay1 = cmd[15:8];
        if ($urandom_range(0, 3) == 0) begin
            d.pay0 = 8'h00;
        end
        return d;
    endfunction

    // directed frames with all filters open
    task automatic run_directed();
        frame_desc_t d;
        logic [15:0] cmds[5] = '{ENIP_REG, ENIP_UNREG, ENIP_RR, ENIP_UNIT, 16'h6500};
        // ethertype classes
        d = ipv4_desc(PROTO_UDP, 16'd1, 16'd2, 8'h50, 0);
        d.etype = 16'h0000;
        send_frame(d, 14);
        d.etype = ETH_LEN_LIMIT - 16'd1;
        send_frame(d, 14);
        d.etype = ETH_LEN_LIMIT;
        send_frame(d, 20);
        d.etype = ET_LLDP;
        send_frame(d, 14);
        d.etype = ET_VLAN;
        send_frame(d, 14);
        d.etype = ET_ARP;
        send_frame(d, 14);
        d.etype = ET_IPV6;
        send_frame(d, 14);
        d.etype = 16'hffff;
        send_frame(d, 14);
        // frames that end before the ethertype
        d.etype = ET_IPV4;
        send_frame(d, 1);
        send_frame(d, 13);
        // protocols other than tcp and udp
        d.proto = PROTO_ICMP;
        send_frame(d, 34);
        d.proto = PROTO_IGMP;
        send_frame(d, 34);
        d.proto = 8'hff;
        send_frame(d, 34);
        // udp, whole ports and cut inside the ports
        d = ipv4_desc(PROTO_UDP, 16'hffff, 16'h0000, 8'h50, 8);
        send_frame(d, 38);
        send_frame(d, 36);
        // tcp with empty payload and with a single byte
        d = ipv4_desc(PROTO_TCP, 16'd1234, 16'd80, 8'h5f, 0);
        send_frame(d, 47);
        d = ipv4_desc(PROTO_TCP, 16'd1234, 16'd80, 8'h50, 1);
        d.pay0 = 8'h00;
        send_frame(d, 55);
        d.pay0 = 8'hff;
        send_frame(d, 55);
        d = ipv4_desc(PROTO_TCP, PORT_HTTPS, 16'd80, 8'h50, 6);
        send_frame(d, 60);
        // enip commands on the destination port
        d = ipv4_desc(PROTO_TCP, 16'd5000, PORT_ENIP, 8'h50, 24);
        foreach (cmds[k]) begin
            d.pay0 = cmds[k][7:0];
            d.pay1 = cmds[k][15:8];
            send_frame(d, 56);
        end
        // largest tcp header, enip on the source port, whole and cut inside the command
        d = ipv4_desc(PROTO_TCP, PORT_ENIP, 16'd0, 8'hf0, 2);
        d.pay0 = ENIP_UNIT[7:0];
        d.pay1 = ENIP_UNIT[15:8];
        send_frame(d, 96);
        send_frame(d, 95);
        // single nonzero payload byte on the enip port reads the command
        d = ipv4_desc(PROTO_TCP, PORT_ENIP, PORT_ENIP, 8'h50, 1);
        d.pay0 = ENIP_RR[7:0];
        d.pay1 = ENIP_RR[15:8];
        send_frame(d, 56);
        // tcp data offset below five words
        d = ipv4_desc(PROTO_TCP, 16'd1, 16'd2, 8'h4f, 0);
        send_frame(d, 50);
        d.doff = 8'h00;
        send_frame(d, 50);
        // negative and oversized payload lengths
        d = ipv4_desc(PROTO_TCP, 16'd10, 16'd20, 8'h50, 0);
        d.tot_len = 16'h0000;
        send_frame(d, 60);
        d.tot_len = 16'hffff;
        d.dp = PORT_ENIP;
        send_frame(d, 56);
        // frame long enough to saturate the byte counter
        d = ipv4_desc(PROTO_UDP, 16'd7, 16'd9, 8'h50, 0);
        send_frame(d, 65600);
    endtask

    // main sequence
    initial begin
        frame_desc_t d;
        int          len;
        int          mode;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        // random frames over several filter settings
        for (int phase = 0; phase < 6; phase++) begin
            wait_idle();
            mode = (phase == 0) ? CFG_ZERO : (phase == 1) ? CFG_ONES : CFG_RANDOM;
            set_filters(mode);
            no_idle = (phase == 2);
            for (int n = 0; n < 10; n++) begin
                if (phase == 3 && n == 5) begin
                    wait_idle();
                end
                d = random_desc();
                if (d.etype == ET_IPV4) begin
                    len = int'(TCP_BASE) + int'(d.doff[7:4]) * 4 + 2 + $urandom_range(0, 6);
                    if (len < 47) begin
                        len = 47 + $urandom_range(0, 3);
                    end
                end else begin
                    len = $urandom_range(14, 24);
                end
                if ($urandom_range(0, 99) < 15) begin
                    len = $urandom_range(1, len);
                end
                send_frame(d, len);
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // drain and let the pipeline settle
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.verdicts_due.size() == 0) begin
            $display("eth_ipv4_l4_packet_filter_tb OK");
        end else begin
            $display("eth_ipv4_l4_packet_filter_tb NOT OK");
        end
        $finish;
    end

endmodule
